// File: sv/writ_pkg.sv
// Shared types, codes and constants for the work/rest interval timer.
// Used by writ_mod_unit and work_rest_interval_timer_unit; depends on nothing.
package writ_pkg;

  // Command codes carried on kind
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_PAUSE = 3'd3;
  localparam logic [2:0] KIND_SKIP  = 3'd4;
  localparam logic [2:0] KIND_ADD   = 3'd5;

  // Phase codes
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_WORK = 2'd1;
  localparam logic [1:0] PHASE_REST = 2'd2;

  // Report codes carried on event_kind
  localparam logic EV_TICK  = 1'b0;
  localparam logic EV_PHASE = 1'b1;

  // Configuration register indexes
  localparam logic REG_WORK = 1'b0;
  localparam logic REG_REST = 1'b1;

  localparam logic [6:0] WORK_MIN_RESET = 7'd25;
  localparam logic [6:0] REST_MIN_RESET = 7'd5;

  // Clamp limits for add time, in seconds
  localparam logic [15:0] MIN_SECONDS = 16'd60;
  localparam logic [15:0] MAX_SECONDS = 16'd5940;

  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 13;

  // Status of the serial remainder unit
  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] rem;
  } div_status_t;

  // Minutes to seconds as shift and subtract: m*64 - m*4
  function automatic logic [15:0] times60(input logic [7:0] m);
    logic [15:0] m16;
    m16 = {8'd0, m};
    return (m16 << 6) - (m16 << 2);
  endfunction

endpackage

// File: sv/work_rest_interval_timer_unit.sv
// Top level of the work/rest interval timer: command decode, phase state,
// add-time rounding and the result register. Depends on writ_pkg, writ_mod_unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | into      | in_valid / in_ready  | kind, add_minutes
//   out     | out of    | out_valid / out_ready| event_kind, phase, remaining_seconds,
//           |           |                      | elapsed_seconds, last
//   cfg     | into      | cfg_write            | cfg_index, cfg_data
//
// Stop, pause and ignored commands leave in_ready high, so the next transfer can follow at once.
// Tick, start and skip apply at the transfer; the emit state then loads each result,
// and in_ready stays low until the last one is loaded.
// Add time: 16 remainder steps, then the divide state sees done, the adjust state rounds
// and clamps, and the emit state loads the result.
// A result waiting in the output register holds the sequencer, and with it in_ready.
// Synchronous reset clears the phase, times and sequencer; minutes go to 25/5.
module work_rest_interval_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic signed [7:0] add_minutes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        event_kind,
  output logic [1:0]  phase,
  output logic [15:0] remaining_seconds,
  output logic [15:0] elapsed_seconds,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ADJ  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state;
  logic [6:0]  work_minutes;
  logic [6:0]  rest_minutes;
  logic [1:0]  phase_now;
  logic        running;
  logic [15:0] seconds_left;
  logic [15:0] seconds_spent;
  logic        pend_two;
  logic        add_neg;
  logic [writ_pkg::DIVISOR_W-1:0] add_mag;

  logic        accept;
  logic        take_out;
  logic        mins_neg;
  logic [7:0]  mins_abs;
  logic [15:0] mag_full;
  logic [writ_pkg::DIVISOR_W-1:0] mag_in;
  logic        add_go;
  logic [1:0]  adv_phase;
  logic [15:0] adv_seconds;
  logic signed [17:0] now_s;
  logic signed [17:0] next_s;
  logic [15:0] clamped;
  writ_pkg::div_status_t div_st;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign take_out = !out_valid || out_ready;

  // Decode the add-time increment magnitude
  always_comb begin
    mins_neg = add_minutes[7];
    mins_abs = mins_neg ? 8'(-add_minutes) : 8'(add_minutes);
    mag_full = writ_pkg::times60(mins_abs);
    mag_in   = mag_full[writ_pkg::DIVISOR_W-1:0];
    add_go   = (add_minutes != 8'sd0)
               && !(mins_neg && (seconds_left < writ_pkg::MIN_SECONDS));
  end

  // Next phase and its reload time; start always goes to the work phase
  always_comb begin
    if (kind != writ_pkg::KIND_START && phase_now == writ_pkg::PHASE_WORK) begin
      adv_phase = writ_pkg::PHASE_REST;
    end else begin
      adv_phase = writ_pkg::PHASE_WORK;
    end
    adv_seconds = writ_pkg::times60((adv_phase == writ_pkg::PHASE_WORK)
                                    ? {1'b0, work_minutes} : {1'b0, rest_minutes});
  end

  // Round to the next increment multiple in the sign's direction, then clamp
  always_comb begin
    now_s = $signed({2'b00, seconds_left});
    if (add_neg) begin
      next_s = (div_st.rem != '0) ? now_s - $signed(18'(div_st.rem))
                                  : now_s - $signed(18'(add_mag));
    end else begin
      next_s = now_s + $signed(18'(add_mag)) - $signed(18'(div_st.rem));
    end
    priority if (next_s > $signed({2'b00, writ_pkg::MAX_SECONDS})) begin
      clamped = writ_pkg::MAX_SECONDS;
    end else if (next_s < $signed({2'b00, writ_pkg::MIN_SECONDS})) begin
      clamped = writ_pkg::MIN_SECONDS;
    end else begin
      clamped = next_s[15:0];
    end
  end

  writ_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && kind == writ_pkg::KIND_ADD && add_go),
    .dividend (seconds_left),
    .divisor  (mag_in),
    .status   (div_st)
  );

  // Hold the configured minutes
  always_ff @(posedge clk) begin
    if (rst) begin
      work_minutes <= writ_pkg::WORK_MIN_RESET;
      rest_minutes <= writ_pkg::REST_MIN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == writ_pkg::REG_WORK) begin
        work_minutes <= cfg_data;
      end else begin
        rest_minutes <= cfg_data;
      end
    end
  end

  // Latch the increment for the rounding step
  always_ff @(posedge clk) begin
    if (accept) begin
      add_neg <= mins_neg;
      add_mag <= mag_in;
    end
  end

  // Sequencer and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_now     <= writ_pkg::PHASE_IDLE;
      running       <= 1'b0;
      seconds_left  <= '0;
      seconds_spent <= '0;
      pend_two      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (kind)
              writ_pkg::KIND_TICK: begin
                if (running) begin
                  state <= S_EMIT;
                  if (seconds_left != '0) begin
                    seconds_left <= seconds_left - 16'd1;
                    if (seconds_spent != 16'hFFFF) begin
                      seconds_spent <= seconds_spent + 16'd1;
                    end
                    pend_two <= 1'b0;
                  end else begin
                    phase_now     <= adv_phase;
                    seconds_left  <= adv_seconds;
                    seconds_spent <= '0;
                    pend_two      <= 1'b1;
                  end
                end
              end
              writ_pkg::KIND_START, writ_pkg::KIND_SKIP: begin
                state         <= S_EMIT;
                phase_now     <= adv_phase;
                seconds_left  <= adv_seconds;
                seconds_spent <= '0;
                running       <= 1'b1;
                pend_two      <= 1'b1;
              end
              writ_pkg::KIND_STOP: begin
                running   <= 1'b0;
                phase_now <= writ_pkg::PHASE_IDLE;
              end
              writ_pkg::KIND_PAUSE: begin
                running <= !running;
              end
              writ_pkg::KIND_ADD: begin
                if (add_go) begin
                  state <= S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          seconds_left <= clamped;
          running      <= 1'b1;
          pend_two     <= 1'b0;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (take_out) begin
            if (pend_two) begin
              pend_two <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: phase report first when two results are due
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && take_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && take_out) begin
      event_kind        <= pend_two ? writ_pkg::EV_PHASE : writ_pkg::EV_TICK;
      last              <= !pend_two;
      phase             <= phase_now;
      remaining_seconds <= seconds_left;
      elapsed_seconds   <= seconds_spent;
    end
  end

`ifndef SYNTHESIS
  // The remainder unit finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("remainder done outside the divide state");

  // The remainder is below the increment it was taken by
  a_rem_below_mag: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> div_st.rem < add_mag)
    else $error("remainder not below increment");

  // Add time always leaves the remaining time inside the clamp limits
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ADJ |=> (seconds_left >= writ_pkg::MIN_SECONDS
                        && seconds_left <= writ_pkg::MAX_SECONDS && running))
    else $error("add time left seconds outside limits");

  // A phase report is never the final result of its transfer
  a_phase_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == writ_pkg::EV_PHASE) |-> !last)
    else $error("phase report marked last");

  // The phase register never holds the unused code
  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    phase_now != 2'd3)
    else $error("phase register corrupt");
`endif

endmodule

// File: sv/writ_mod_unit.sv
// Serial remainder unit: one restoring compare-and-subtract step per cycle.
// Depends on writ_pkg for widths and the status struct.
module writ_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [writ_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [writ_pkg::DIVISOR_W-1:0]  divisor,
  output writ_pkg::div_status_t           status
);

  logic                            active;
  logic                            done;
  logic [3:0]                      count;
  logic [writ_pkg::DIVIDEND_W-1:0] shreg;
  logic [writ_pkg::DIVISOR_W-1:0]  rem;
  logic [writ_pkg::DIVISOR_W-1:0]  dvs;

  logic [writ_pkg::DIVISOR_W:0]    trial;
  logic [writ_pkg::DIVISOR_W:0]    diff;
  logic                            fits;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, shreg[writ_pkg::DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  // Control: run one step per cycle, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= '0;
      end else if (active) begin
        count <= count + 4'd1;
        if (count == 4'(writ_pkg::DIVIDEND_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (active) begin
      shreg <= shreg << 1;
      rem   <= fits ? diff[writ_pkg::DIVISOR_W-1:0] : trial[writ_pkg::DIVISOR_W-1:0];
    end
  end

  assign status.done = done;
  assign status.rem  = rem;

endmodule
